/* rtl/packed_transid_codec_top_defines.svh */
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef PACKED_TRANSID_CODEC_TOP_DEFINES_SVH
`define PACKED_TRANSID_CODEC_TOP_DEFINES_SVH

// same-cycle implication
`define PTC_ASSERT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ptc assertion failed");

`endif

/* rtl/ptc_pkg.sv */
`default_nettype none
package ptc_pkg;

	localparam int ID_W = 48;
	localparam int BYTE_BITS = 8;
	localparam int ID_BYTES = ID_W / BYTE_BITS;
	localparam int CNT_W = 3;

	localparam logic [7:0] ONE_BYTE_LIMIT = 8'd244;
	localparam logic [7:0] PREFIX_BASE = 8'd249;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic            mode;
		logic [ID_W-1:0] id_in;
		logic [7:0]      coded_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0]      coded_out;
		logic [ID_W-1:0] id_out;
		logic            last;
		logic            error;
	} out_item_t;

	// pre-computed encode info for one id
	typedef struct packed {
		logic             err;
		logic             single;
		logic [CNT_W-1:0] n;
		logic [ID_W-1:0]  v;
	} enc_info_t;

endpackage
`default_nettype wire

/* rtl/ptc_enc_prep.sv */
`default_nettype none
module ptc_enc_prep #(
	parameter int MAX_ID_BYTES = 6
) (
	input  wire logic [ptc_pkg::ID_W-1:0] id,
	input  wire logic [ptc_pkg::ID_W-1:0] base,
	output ptc_pkg::enc_info_t            info
);

	localparam int LIM_BITS = (MAX_ID_BYTES * ptc_pkg::BYTE_BITS < ptc_pkg::ID_W) ?
		MAX_ID_BYTES * ptc_pkg::BYTE_BITS : ptc_pkg::ID_W;
	localparam logic [ptc_pkg::ID_W-1:0] FIT_MASK = (LIM_BITS == ptc_pkg::ID_W) ?
		{ptc_pkg::ID_W{1'b1}} : ((ptc_pkg::ID_W)'(1) << LIM_BITS) - (ptc_pkg::ID_W)'(1);

	logic [ptc_pkg::ID_W:0]   diff;
	logic [ptc_pkg::ID_W:0]   v_full;
	logic                     below;
	logic                     too_big;
	logic [ptc_pkg::CNT_W-1:0] n;

	assign diff    = {1'b0, id} - {1'b0, base};
	assign below   = diff[ptc_pkg::ID_W];
	assign v_full  = {diff[ptc_pkg::ID_W-1:0], 1'b0};
	assign too_big = v_full[ptc_pkg::ID_W] | (|(v_full[ptc_pkg::ID_W-1:0] & ~FIT_MASK));

	// count of significant bytes
	always_comb begin
		n = '0;
		for (int i = 0; i < ptc_pkg::ID_BYTES; i++) begin
			if (v_full[i*ptc_pkg::BYTE_BITS +: ptc_pkg::BYTE_BITS] != '0) begin
				n = ptc_pkg::CNT_W'(i + 1);
			end
		end
	end

	assign info.err    = below | too_big;
	assign info.single = (v_full[ptc_pkg::ID_W-1:0] <
		{{(ptc_pkg::ID_W-8){1'b0}}, ptc_pkg::ONE_BYTE_LIMIT});
	assign info.n      = n;
	assign info.v      = v_full[ptc_pkg::ID_W-1:0];

endmodule
`default_nettype wire

/* rtl/ptc_dec.sv */
`default_nettype none
module ptc_dec #(
	parameter int MAX_ID_BYTES = 6
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [ptc_pkg::ID_W-1:0] base,
	input  wire logic [7:0]               coded,
	input  wire logic                     fire,
	output logic                          has_res,
	output ptc_pkg::out_item_t            res
);

	localparam logic [3:0] MAX_B = 4'(MAX_ID_BYTES);

	logic [ptc_pkg::ID_W-1:0]  acc_q, acc_nxt;
	logic [ptc_pkg::CNT_W-1:0] left_q, left_nxt;
	logic                      infield_q, infield_nxt;
	logic [7:0]                cnt;

	assign cnt = coded - ptc_pkg::PREFIX_BASE;

	always_comb begin
		acc_nxt     = acc_q;
		left_nxt    = left_q;
		infield_nxt = infield_q;
		has_res     = 1'b0;
		res         = '0;
		if (infield_q) begin
			acc_nxt  = {acc_q[ptc_pkg::ID_W-9:0], coded};
			left_nxt = left_q - ptc_pkg::CNT_W'(1);
			if (left_nxt == '0) begin
				infield_nxt = 1'b0;
				has_res     = 1'b1;
				res.id_out  = {1'b0, acc_nxt[ptc_pkg::ID_W-1:1]} + base;
			end
		end else if (coded < ptc_pkg::ONE_BYTE_LIMIT) begin
			has_res    = 1'b1;
			res.id_out = {{(ptc_pkg::ID_W-7){1'b0}}, coded[7:1]} + base;
		end else if (coded <= ptc_pkg::PREFIX_BASE || {1'b0, cnt[2:0]} > MAX_B) begin
			has_res   = 1'b1;
			res.error = 1'b1;
		end else begin
			left_nxt    = cnt[ptc_pkg::CNT_W-1:0];
			acc_nxt     = '0;
			infield_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			left_q    <= '0;
			infield_q <= 1'b0;
		end else if (fire) begin
			acc_q     <= acc_nxt;
			left_q    <= left_nxt;
			infield_q <= infield_nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/packed_transid_codec_top.sv */
// Packed transaction-id codec.
// Requests enter on in_valid/in_ready with in_data; results leave on
// out_valid/out_ready with out_data. base_id is written on cfg_valid with
// cfg_data (cfg_ready is always high); the user must write it only while
// no request is in flight, which the block itself does not enforce.
// A request waits in the input stage while the encoder emits its bytes one
// per cycle into the output register, when that register is free.
// Encode: 1 result (single byte or error) or n+1 results (prefix plus n
// bytes), which the request yields while it waits in the input stage.
// Decode: one request per cycle unless the output register stalls it;
// field bytes before the last give no result.
// Reset clears decode state, base_id, both valid flags and the byte counter.
// When out_ready is low the output register holds its result and the input
// stage stalls behind it if it has a result to send; in_ready drops while
// the input stage holds a request that still has a result to send.
`default_nettype none
module packed_transid_codec_top #(
	parameter int MAX_ID_BYTES = 6
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire ptc_pkg::in_item_t        in_data,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output ptc_pkg::out_item_t            out_data,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [ptc_pkg::ID_W-1:0] cfg_data
);

	logic [ptc_pkg::ID_W-1:0]  base_q;
	ptc_pkg::enc_info_t        info_in, info_s1;
	logic                      valid_s1;
	logic                      mode_s1;
	logic [7:0]                coded_s1;
	logic [ptc_pkg::CNT_W-1:0] k_q;
	ptc_pkg::out_item_t        enc_res, dec_res, res;
	logic                      dec_has;
	logic                      enc_last;
	logic                      need_out, out_slot, emit, s1_done, dec_fire;
	logic [ptc_pkg::ID_BYTES-1:0][7:0] v_bytes;
	logic [ptc_pkg::CNT_W-1:0] idx;
	logic                      out_valid_q;
	ptc_pkg::out_item_t        out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	ptc_enc_prep #(.MAX_ID_BYTES(MAX_ID_BYTES)) u_prep (
		.id   (in_data.id_in),
		.base (base_q),
		.info (info_in)
	);

	ptc_dec #(.MAX_ID_BYTES(MAX_ID_BYTES)) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.base    (base_q),
		.coded   (coded_s1),
		.fire    (dec_fire),
		.has_res (dec_has),
		.res     (dec_res)
	);

	// encode byte selection
	assign v_bytes = info_s1.v;
	assign idx     = info_s1.n - k_q;

	always_comb begin
		enc_res  = '0;
		enc_last = 1'b0;
		if (k_q == '0) begin
			if (info_s1.err) begin
				enc_res.last  = 1'b1;
				enc_res.error = 1'b1;
				enc_last      = 1'b1;
			end else if (info_s1.single) begin
				enc_res.coded_out = info_s1.v[7:0];
				enc_res.last      = 1'b1;
				enc_last          = 1'b1;
			end else begin
				enc_res.coded_out = ptc_pkg::PREFIX_BASE + {5'b0, info_s1.n};
			end
		end else begin
			enc_res.coded_out = v_bytes[idx];
			enc_last          = (k_q == info_s1.n);
			enc_res.last      = enc_last;
		end
	end

	assign need_out = (mode_s1 == ptc_pkg::MODE_ENCODE) | dec_has;
	assign out_slot = !out_valid_q | out_ready;
	assign emit     = valid_s1 & need_out & out_slot;
	assign s1_done  = valid_s1 & (!need_out | out_slot) &
		((mode_s1 == ptc_pkg::MODE_DECODE) | enc_last);
	assign dec_fire = s1_done & (mode_s1 == ptc_pkg::MODE_DECODE);
	assign in_ready = !valid_s1 | s1_done;
	assign res      = (mode_s1 == ptc_pkg::MODE_ENCODE) ? enc_res : dec_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1  <= in_data.mode;
			coded_s1 <= in_data.coded_in;
			info_s1  <= info_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (emit && mode_s1 == ptc_pkg::MODE_ENCODE) begin
			k_q <= enc_last ? '0 : k_q + ptc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_slot) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

/* rtl/ptc_checker.sv */
`default_nettype none
`include "packed_transid_codec_top_defines.svh"
module ptc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire ptc_pkg::out_item_t out_data
);

	`PTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`PTC_ASSERT(a_err_zero, out_valid && out_data.error,
		out_data.coded_out == '0 && out_data.id_out == '0)
	`PTC_ASSERT(a_id_plain, out_valid && out_data.id_out != '0,
		!out_data.last && !out_data.error && out_data.coded_out == '0)

endmodule

bind packed_transid_codec_top ptc_checker u_chk (.*);
`default_nettype wire
